@@ design/pwo_pkg.sv @@
// Shared constants, codes and types of the phase-warped waveform oscillator.
package pwo_pkg;

	localparam int STEP_BITS         = 32;
	localparam int TUNING_BITS       = 16;
	localparam int CENTRE_BITS       = 16;
	localparam int WAVE_BITS         = 3;
	localparam int CFG_INDEX_BITS    = 2;
	localparam int CFG_DATA_BITS     = 16;
	localparam int WARP_BITS         = 32;
	localparam int DIV_STEPS         = 31;
	localparam int DIV_COUNT_BITS    = 5;
	localparam int PRODUCT_FRAC_BITS = 44;

	localparam int PHASE_BITS_DEF       = 32;
	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int AMPLITUDE_BITS_DEF   = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM     = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TUNING       = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_CENTRE = 2'd2;

	localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
	localparam logic [WAVE_BITS-1:0] WAVE_PULSE    = 3'd1;
	localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd2;
	localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 3'd3;
	localparam logic [WAVE_BITS-1:0] WAVE_RSAW     = 3'd4;

	localparam logic [WAVE_BITS-1:0]   WAVEFORM_RESET = WAVE_SINE;
	localparam logic [TUNING_BITS-1:0] TUNING_RESET   = 16'd4096;
	localparam logic [CENTRE_BITS-1:0] CENTRE_RESET   = 16'd32768;
	localparam logic [CENTRE_BITS-1:0] CENTRE_MIN     = 16'd655;
	localparam logic [CENTRE_BITS-1:0] CENTRE_MAX     = 16'd64880;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	typedef logic [WARP_BITS-1:0] warp_t;

	typedef struct packed {
		logic map;
		logic read;
	} shp_ctrl_t;

endpackage

@@ design/pwo_step_if.sv @@
// Request channel that carries one phase step.
interface pwo_step_if import pwo_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STEP_BITS-1:0] phase_inc;

	modport source (output valid, output phase_inc, input ready);
	modport sink (input valid, input phase_inc, output ready);
endinterface

@@ design/pwo_sample_if.sv @@
// Request channel that carries one output sample.
interface pwo_sample_if import pwo_pkg::*; #(
	parameter int AMPLITUDE_BITS = AMPLITUDE_BITS_DEF
) ();
	logic                             valid;
	logic                             ready;
	logic signed [AMPLITUDE_BITS-1:0] amplitude;

	modport source (output valid, output amplitude, input ready);
	modport sink (input valid, input amplitude, output ready);
endinterface

@@ design/pwo_div.sv @@
// Restoring divider producing one quotient bit per cycle for the phase warp.
module pwo_div import pwo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  warp_t                num,
	input  warp_t                den,
	output logic                 done,
	output logic [DIV_STEPS-1:0] quot
);

	logic                      busy_q;
	logic                      done_q;
	logic [DIV_COUNT_BITS-1:0] cnt_q;
	warp_t                     rem_q;
	warp_t                     den_q;
	logic [DIV_STEPS-1:0]      quot_q;
	logic [WARP_BITS:0]        trial;
	logic [WARP_BITS:0]        diff;
	logic                      fits;

	assign trial = {rem_q, 1'b0};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_COUNT_BITS'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[WARP_BITS-1:0] : trial[WARP_BITS-1:0];
			quot_q <= {quot_q[DIV_STEPS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ design/pwo_shaper.sv @@
// Waveform shaper: quarter-wave sine table, pulse, triangle and saw mapping with saturation.
module pwo_shaper import pwo_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int AMPLITUDE_BITS   = AMPLITUDE_BITS_DEF
) (
	input  logic                             clk,
	input  shp_ctrl_t                        ctrl,
	input  warp_t                            w,
	input  logic [WAVE_BITS-1:0]             waveform,
	output logic signed [AMPLITUDE_BITS-1:0] amplitude
);

	localparam int     IW  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int     AW  = AMPLITUDE_BITS + 3;
	localparam int     SW  = AMPLITUDE_BITS - 1;
	localparam int     FW  = WARP_BITS - 2;
	localparam longint FS  = 64'sd1 <<< (AMPLITUDE_BITS - 1);
	localparam logic signed [AW-1:0] FS_V  = AW'(FS);
	localparam logic signed [AW-1:0] FS3_V = AW'(3 * FS);
	localparam logic signed [AW-1:0] MAX_V = AW'(FS - 1);
	localparam logic signed [AW-1:0] MIN_V = AW'(-FS);

	logic [SW-1:0]    sine_rom [SINE_TABLE_DEPTH+1];
	logic [FW+IW-1:0] idx_prod;
	logic [IW-1:0]    idx_i;
	logic [IW-1:0]    idx_j;
	warp_t            w_s1;
	logic [IW-1:0]    idx_s1;
	logic [SW-1:0]    sine_s2;

	logic signed [AW-1:0] sx;
	logic signed [AW-1:0] sine_v;
	logic signed [AW-1:0] wave_v;

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint X   = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
		localparam longint X2  = (X * X) >> 30;
		localparam longint T1  = ((X * X2) >> 30) / 6;
		localparam longint T2  = ((T1 * X2) >> 30) / 20;
		localparam longint T3  = ((T2 * X2) >> 30) / 42;
		localparam longint T4  = ((T3 * X2) >> 30) / 72;
		localparam longint T5  = ((T4 * X2) >> 30) / 110;
		localparam longint T6  = ((T5 * X2) >> 30) / 156;
		localparam longint T7  = ((T6 * X2) >> 30) / 210;
		localparam longint T8  = ((T7 * X2) >> 30) / 272;
		localparam longint SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8;
		localparam longint POS = (SUM < 0) ? 0 : SUM;
		localparam longint RND = (POS * FS + (64'sd1 <<< 29)) >>> 30;
		localparam longint ENT = (RND > FS - 1) ? FS - 1 : RND;
		assign sine_rom[k] = SW'(ENT);
	end

	// Table index is the in-quadrant phase scaled to the table depth.
	assign idx_prod = w[FW-1:0] * IW'(SINE_TABLE_DEPTH);
	assign idx_i    = idx_prod[FW +: IW];
	assign idx_j    = w[FW] ? IW'(SINE_TABLE_DEPTH) - idx_i : idx_i;

	always_ff @(posedge clk) begin
		if (ctrl.map) begin
			w_s1   <= w;
			idx_s1 <= idx_j;
		end
		if (ctrl.read) begin
			sine_s2 <= sine_rom[idx_s1];
		end
	end

	assign sx     = signed'(AW'(w_s1[WARP_BITS-1 -: SW]));
	assign sine_v = w_s1[WARP_BITS-1] ? -signed'(AW'(sine_s2)) : signed'(AW'(sine_s2));

	always_comb begin
		case (waveform)
			WAVE_SINE:     wave_v = sine_v;
			WAVE_PULSE:    wave_v = w_s1[WARP_BITS-1] ? MAX_V : MIN_V;
			WAVE_TRIANGLE: wave_v = sx[SW-1] ? FS3_V - (sx <<< 2) : (sx <<< 2) - FS_V;
			WAVE_SAW:      wave_v = (sx <<< 1) - FS_V;
			WAVE_RSAW:     wave_v = FS_V - (sx <<< 1);
			default:       wave_v = '0;
		endcase
	end

	always_comb begin
		if (wave_v > MAX_V) begin
			amplitude = AMPLITUDE_BITS'(MAX_V);
		end else if (wave_v < MIN_V) begin
			amplitude = AMPLITUDE_BITS'(MIN_V);
		end else begin
			amplitude = AMPLITUDE_BITS'(wave_v);
		end
	end

endmodule

@@ design/phase_warped_waveform_oscillator_core.sv @@
// Top level of the phase-warped waveform oscillator: sequencer, registers and phase accumulator.
//
// Each request carries a phase step that is scaled by the tuning register and added to the
// phase accumulator; the phase is then warped about the pulse centre and shaped into one
// sample of the selected waveform. A request passes through scaling, accumulation and divider
// setup, then the restoring divider at one quotient bit per cycle, and then table lookup,
// shaping and output, where it waits while the output register holds an unclaimed sample.
// A finished sample waits in the output register, so the next request can be taken while
// it is still unclaimed. Configuration writes take effect on the next cycle and should be
// made only while no request is in progress.
module phase_warped_waveform_oscillator_core import pwo_pkg::*; #(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int AMPLITUDE_BITS   = AMPLITUDE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	pwo_step_if.sink                  step,
	pwo_sample_if.source              sample
);

	localparam int PROD_BITS = STEP_BITS + TUNING_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_SETUP = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]                       state_q;
	logic [WAVE_BITS-1:0]             waveform_q;
	logic [TUNING_BITS-1:0]           tuning_q;
	logic [CENTRE_BITS-1:0]           centre_q;
	logic [PHASE_BITS-1:0]            phase_q;
	logic                             out_valid_q;
	logic [STEP_BITS-1:0]             step_q;
	logic [PHASE_BITS-1:0]            inc_q;
	logic                             lo_q;
	logic signed [AMPLITUDE_BITS-1:0] amp_q;

	logic [PROD_BITS-1:0]             prod;
	logic [PHASE_BITS-1:0]            inc;
	warp_t                            p;
	warp_t                            c;
	logic                             lo;
	logic                             div_start;
	logic                             div_done;
	logic [DIV_STEPS-1:0]             quot;
	warp_t                            w;
	shp_ctrl_t                        shp_ctrl;
	logic signed [AMPLITUDE_BITS-1:0] shp_amp;
	logic                             load_out;
	logic [CENTRE_BITS-1:0]           centre_clamped;

	assign prod = step_q * tuning_q;

	if (PHASE_BITS <= PRODUCT_FRAC_BITS) begin : g_inc_shr
		assign inc = PHASE_BITS'(prod >> (PRODUCT_FRAC_BITS - PHASE_BITS));
	end else begin : g_inc_shl
		assign inc = PHASE_BITS'(prod) << (PHASE_BITS - PRODUCT_FRAC_BITS);
	end

	if (PHASE_BITS >= WARP_BITS) begin : g_p_top
		assign p = phase_q[PHASE_BITS-1 -: WARP_BITS];
	end else begin : g_p_ext
		assign p = {phase_q, {(WARP_BITS - PHASE_BITS){1'b0}}};
	end

	assign c         = {centre_q, {(WARP_BITS - CENTRE_BITS){1'b0}}};
	assign lo        = p < c;
	assign div_start = state_q == ST_SETUP;
	assign w         = {~lo_q, quot};

	assign shp_ctrl.map  = (state_q == ST_DIV) && div_done;
	assign shp_ctrl.read = state_q == ST_READ;

	assign load_out = (state_q == ST_OUT) && (!out_valid_q || sample.ready);

	assign centre_clamped = (cfg_wdata < CENTRE_MIN) ? CENTRE_MIN :
		((cfg_wdata > CENTRE_MAX) ? CENTRE_MAX : cfg_wdata);

	pwo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (lo ? p : p - c),
		.den    (lo ? c : warp_t'(0) - c),
		.done   (div_done),
		.quot   (quot)
	);

	pwo_shaper #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.AMPLITUDE_BITS   (AMPLITUDE_BITS)
	) u_shaper (
		.clk       (clk),
		.ctrl      (shp_ctrl),
		.w         (w),
		.waveform  (waveform_q),
		.amplitude (shp_amp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			waveform_q  <= WAVEFORM_RESET;
			tuning_q    <= TUNING_RESET;
			centre_q    <= CENTRE_RESET;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WAVEFORM:     waveform_q <= cfg_wdata[WAVE_BITS-1:0];
					REG_TUNING:       tuning_q   <= cfg_wdata[TUNING_BITS-1:0];
					REG_PULSE_CENTRE: centre_q   <= centre_clamped;
					default:          ;
				endcase
			end
			if (state_q == ST_ACC) begin
				phase_q <= phase_q + inc_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (sample.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (step.valid) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_SETUP;
				ST_SETUP: state_q <= ST_DIV;
				ST_DIV:   if (div_done) state_q <= ST_READ;
				ST_READ:  state_q <= ST_OUT;
				ST_OUT:   if (load_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.ready) begin
			step_q <= step.phase_inc;
		end
		if (state_q == ST_MUL) begin
			inc_q <= inc;
		end
		if (state_q == ST_SETUP) begin
			lo_q <= lo;
		end
		if (load_out) begin
			amp_q <= shp_amp;
		end
	end

	assign step.ready       = state_q == ST_IDLE;
	assign sample.valid     = out_valid_q;
	assign sample.amplitude = amp_q;

endmodule

@@ design/pwo_checker.sv @@
// Port-level checks of the oscillator core and the bind that attaches them.
module pwo_checker import pwo_pkg::*; #(
	parameter int AMPLITUDE_BITS = AMPLITUDE_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             step_valid,
	input logic                             step_ready,
	input logic                             sample_valid,
	input logic                             sample_ready,
	input logic signed [AMPLITUDE_BITS-1:0] amplitude
);

	// Only one request is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_ready |=> !step_ready)
		else $error("core ready again right after accepting a request");

	// A sample cannot appear in the cycle after a request is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_ready |=> !$rose(sample_valid))
		else $error("sample appeared too soon after a request");

	a_sample_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(amplitude))
		else $error("pending sample dropped or changed");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !sample_valid)
		else $error("sample valid during reset");

endmodule

bind phase_warped_waveform_oscillator_core pwo_checker #(
	.AMPLITUDE_BITS (AMPLITUDE_BITS)
) u_pwo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.step_valid   (step.valid),
	.step_ready   (step.ready),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.amplitude    (sample.amplitude)
);
